/* design/rbd_pkg.sv */
// ============================================================================
// rbd_pkg: shared types and constants of the run-length byte decoder
// Holds the job record passed from the front end to the back end, the token
// phase and status codes, and the default sizes.
// ============================================================================
`default_nettype none

package rbd_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int BYTES_PER_RESULT_DEF = 8;
    localparam int QUEUE_DEPTH_DEF      = 2;

    // Stream header: a little-endian 64-bit target size.
    localparam logic [3:0] HDR_BYTES = 4'd8;

    // Token decoding.
    localparam logic [7:0] LIT_LIMIT = 8'd128;
    localparam logic [7:0] RUN_MASK  = 8'd127;
    localparam logic [7:0] RUN_BIAS  = 8'd4;

    // Token phase codes.
    localparam logic [1:0] PH_TOKEN   = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_RUN     = 2'd2;

    // Stream status codes.
    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // One input word's worth of output: total bytes, of which the first
    // nval carry value and the rest are zero fill.
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] nval;
        logic [7:0] total;
        logic [1:0] status;
    } rbd_job_t;

endpackage

`default_nettype wire

/* design/rbd_front.sv */
// ============================================================================
// rbd_front: header and token parser
// Tracks the header, the token phase and the bytes still owed to the target,
// and turns each accepted input word into one job for the back end.
// ============================================================================
`default_nettype none

module rbd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       in_byte,
    input  wire logic             last,
    input  wire logic             queue_full,
    output logic                  push,
    output rbd_pkg::rbd_job_t     push_job
);

    logic [3:0]  hdr_idx_reg, hdr_idx_next;
    logic [63:0] left_reg, left_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  remain_reg, remain_next;
    logic        finished_reg, finished_next;

    logic [63:0] left_hdr;
    logic [7:0]  n_val;
    logic [7:0]  n_fill;
    logic [7:0]  rem_dec;
    logic [8:0]  total;
    logic [7:0]  emit;
    logic [7:0]  nval;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        hdr_idx_next  = hdr_idx_reg;
        phase_next    = phase_reg;
        remain_next   = remain_reg;
        finished_next = finished_reg;
        left_hdr      = left_reg;
        left_next     = left_reg;
        n_val         = 8'd0;
        n_fill        = 8'd0;
        rem_dec       = 8'd0;
        total         = 9'd0;
        emit          = 8'd0;
        nval          = 8'd0;

        if (!finished_reg)
        begin
            if (hdr_idx_reg < rbd_pkg::HDR_BYTES)
            begin
                left_hdr = left_reg | ({56'd0, in_byte} << {hdr_idx_reg[2:0], 3'b000});
                hdr_idx_next = last ? rbd_pkg::HDR_BYTES : hdr_idx_reg + 4'd1;
            end
            else
            begin
                unique case (phase_reg)
                    rbd_pkg::PH_LITERAL:
                    begin
                        n_val = 8'd1;
                        rem_dec = (remain_reg != 8'd0) ? remain_reg - 8'd1 : 8'd0;
                        remain_next = rem_dec;
                        if (rem_dec == 8'd0)
                        begin
                            phase_next = rbd_pkg::PH_TOKEN;
                        end
                    end
                    rbd_pkg::PH_RUN:
                    begin
                        n_val = remain_reg;
                        remain_next = 8'd0;
                        phase_next = rbd_pkg::PH_TOKEN;
                    end
                    default:
                    begin
                        if (in_byte < rbd_pkg::LIT_LIMIT)
                        begin
                            phase_next = rbd_pkg::PH_LITERAL;
                            remain_next = in_byte + 8'd1;
                        end
                        else
                        begin
                            phase_next = rbd_pkg::PH_RUN;
                            remain_next = (in_byte & rbd_pkg::RUN_MASK) + rbd_pkg::RUN_BIAS;
                        end
                    end
                endcase
            end

            if (hdr_idx_next >= rbd_pkg::HDR_BYTES)
            begin
                // End of stream: an open literal or run is padded with zeros.
                if (last)
                begin
                    if (phase_next == rbd_pkg::PH_LITERAL || phase_next == rbd_pkg::PH_RUN)
                    begin
                        n_fill = remain_next;
                    end
                    phase_next = rbd_pkg::PH_TOKEN;
                    remain_next = 8'd0;
                end
                total = {1'b0, n_val} + {1'b0, n_fill};
                // Clip to the bytes still owed to the target.
                if (left_hdr[63:9] == 55'd0 && left_hdr[8:0] < total)
                begin
                    emit = left_hdr[7:0];
                end
                else
                begin
                    emit = total[7:0];
                end
                nval = (n_val < emit) ? n_val : emit;
                left_next = left_hdr - {56'd0, emit};
                if (left_next == 64'd0 || last)
                begin
                    finished_next = 1'b1;
                    phase_next = rbd_pkg::PH_TOKEN;
                    remain_next = 8'd0;
                end
            end
            else
            begin
                left_next = left_hdr;
            end
        end
    end

    always_comb
    begin
        push_job.value = in_byte;
        push_job.nval = nval;
        push_job.total = emit;
        if (!finished_next)
        begin
            push_job.status = rbd_pkg::ST_BUSY;
        end
        else if (left_next == 64'd0)
        begin
            push_job.status = rbd_pkg::ST_DONE;
        end
        else
        begin
            push_job.status = rbd_pkg::ST_TRUNC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_idx_reg  <= 4'd0;
            left_reg     <= 64'd0;
            phase_reg    <= rbd_pkg::PH_TOKEN;
            remain_reg   <= 8'd0;
            finished_reg <= 1'b0;
        end
        else if (push)
        begin
            hdr_idx_reg  <= hdr_idx_next;
            left_reg     <= left_next;
            phase_reg    <= phase_next;
            remain_reg   <= remain_next;
            finished_reg <= finished_next;
        end
    end

`ifndef SYNTHESIS
    // Once the target is met or the stream has ended, the parser stays done.
    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("front end left the finished state");
`endif

endmodule

`default_nettype wire

/* design/rbd_queue.sv */
// ============================================================================
// rbd_queue: job queue between the parser and the packer
// A small first-in first-out buffer of job records held in flip-flops.
// ============================================================================
`default_nettype none

module rbd_queue #(
    parameter int DEPTH = rbd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire rbd_pkg::rbd_job_t push_job,
    output logic                   full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output rbd_pkg::rbd_job_t      pop_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rbd_pkg::rbd_job_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    // The parser is throttled by full, so a write never lands on a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job queue written while full");
`endif

endmodule

`default_nettype wire

/* design/rbd_back.sv */
// ============================================================================
// rbd_back: output packer
// Expands one job into result words of up to BYTES_PER_RESULT bytes each,
// one word per cycle while out_ready allows, into a registered output stage.
// ============================================================================
`default_nettype none

module rbd_back #(
    parameter int BYTES_PER_RESULT = rbd_pkg::BYTES_PER_RESULT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    input  wire rbd_pkg::rbd_job_t job,
    output logic                   job_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [63:0]            out_bytes,
    output logic [3:0]             out_count,
    output logic                   end_of_burst,
    output logic [1:0]             status
);

    localparam logic [7:0] BPR8 = 8'(BYTES_PER_RESULT);

    logic              cur_valid_reg;
    rbd_pkg::rbd_job_t cur_job_reg;
    logic [7:0]        pos_reg;
    logic              out_valid_reg;
    logic [63:0]       out_bytes_reg, out_bytes_next;
    logic [3:0]        out_count_reg;
    logic              eob_reg;
    logic [1:0]        status_reg;

    logic       slot_free;
    logic       produce;
    logic [7:0] left_bytes;
    logic       last_piece;
    logic [7:0] cnt8;

    assign slot_free  = !out_valid_reg || out_ready;
    assign produce    = cur_valid_reg && slot_free;
    assign left_bytes = cur_job_reg.total - pos_reg;
    assign last_piece = (left_bytes <= BPR8);
    assign cnt8       = last_piece ? left_bytes : BPR8;
    assign job_pop    = job_valid && (!cur_valid_reg || (produce && last_piece));

    // Lane j holds the value while the running byte index is below nval,
    // zero fill after that, and nothing beyond the word's count.
    always_comb
    begin
        logic [8:0] lane_idx;
        lane_idx = 9'd0;
        out_bytes_next = 64'd0;
        for (int j = 0; j < 8; j++)
        begin
            lane_idx = {1'b0, pos_reg} + 9'(j);
            if (j < BYTES_PER_RESULT && 8'(j) < cnt8
                && lane_idx < {1'b0, cur_job_reg.nval})
            begin
                out_bytes_next[8*j +: 8] = cur_job_reg.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (job_pop)
            begin
                cur_valid_reg <= 1'b1;
                pos_reg       <= 8'd0;
            end
            else if (produce && last_piece)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (produce)
            begin
                pos_reg <= pos_reg + BPR8;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_job_reg <= job;
        end
        if (produce)
        begin
            out_bytes_reg <= out_bytes_next;
            out_count_reg <= cnt8[3:0];
            eob_reg       <= last_piece;
            status_reg    <= cur_job_reg.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_bytes    = out_bytes_reg;
    assign out_count    = out_count_reg;
    assign end_of_burst = eob_reg;
    assign status       = status_reg;

`ifndef SYNTHESIS
    a_pos_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (pos_reg <= cur_job_reg.total))
        else $error("packer position ran past the job length");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({4'd0, out_count_reg} <= BPR8))
        else $error("result word holds more bytes than allowed");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_count_reg == 4'd0) |-> eob_reg)
        else $error("empty result word not marked as end of burst");
`endif

endmodule

`default_nettype wire

/* design/rle_byte_decoder_unit.sv */
// ============================================================================
// rle_byte_decoder_unit: streaming run-length byte decoder
// Parses a size header and literal/run tokens and packs the decoded bytes
// into result words of up to BYTES_PER_RESULT bytes.
// ============================================================================
// Usage:
//   The input channel (in_valid/in_ready, in_byte, last) takes one compressed
//   byte per word: eight little-endian size bytes first, then tokens; last
//   marks the final byte. The output channel (out_valid/out_ready) carries
//   out_bytes (first byte in bits 7:0), out_count, end_of_burst and status.
//   Every input word yields one or more result words; the last one of them
//   has end_of_burst set, and a word that decodes to nothing yields one empty
//   result word. Bytes beyond the target size are dropped.
//   The parser takes one input word per cycle while its job queue
//   (QUEUE_DEPTH entries) has room. The packer emits one result word per
//   cycle while the receiver is ready; each input word yields
//   ceil(n / BYTES_PER_RESULT) result words (at least one), n being the
//   bytes it decodes to (up to 131); long runs therefore back-pressure
//   the input through the queue.
//   Reset clears the header, token and size state and empties the queue and
//   the output register. When the receiver stalls, the output register holds
//   its word, the packer waits, and the queue fills before in_ready drops.
// ============================================================================
`default_nettype none

module rle_byte_decoder_unit #(
    parameter int BYTES_PER_RESULT = rbd_pkg::BYTES_PER_RESULT_DEF,
    parameter int QUEUE_DEPTH      = rbd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      out_bytes,
    output logic [3:0]       out_count,
    output logic             end_of_burst,
    output logic [1:0]       status
);

    // Jobs travel from the parser to the packer through the queue.
    logic              push;
    rbd_pkg::rbd_job_t push_job;
    logic              queue_full;
    logic              pop;
    logic              pop_valid;
    rbd_pkg::rbd_job_t pop_job;

    rbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .last       (last),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    rbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_job   (pop_job)
    );

    rbd_back #(
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (pop_valid),
        .job          (pop_job),
        .job_pop      (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_bytes    (out_bytes),
        .out_count    (out_count),
        .end_of_burst (end_of_burst),
        .status       (status)
    );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking testbench for the run-length byte decoder
// Feeds one compressed stream through the decoder: a size header, a short
// list of hand-picked tokens, a long random token section, and a closing
// section that lands the stream exactly on its target size. Every result word
// is checked field by field against its table row or the behavioral decoder.
// ============================================================================

module tb;

    localparam int BPR         = rbd_pkg::BYTES_PER_RESULT_DEF;
    localparam int RAND_WORDS  = 210;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_PAD   = 16;

    // One expected (or observed) result word.
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        eob;
        logic [1:0]  st;
    } dec_result_t;

    // One row of the directed table. When fixed is set, the single result
    // word that the row causes is given in the row itself.
    typedef struct packed {
        logic [7:0]  data;
        logic        lst;
        logic        fixed;
        logic [63:0] f_data;
        logic [3:0]  f_cnt;
        logic [1:0]  f_st;
    } dir_row_t;

    // The header announces a target of 0x18FF = 6399 bytes. It carries both
    // 0x00 and 0xFF, and the target is large enough that the random section
    // never reaches it on its own.
    dir_row_t dir_tab [20] = '{
        '{8'hFF, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'h18, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'h00, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'h00, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'h00, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'h00, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'h00, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'h00, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        // Shortest literal: one byte.
        '{8'h00, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'hA5, 1'b0, 1'b1, 64'hA5, 4'd1, rbd_pkg::ST_BUSY},
        // Shortest run: four copies of 0xFF.
        '{8'h80, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'hFF, 1'b0, 1'b1, 64'hFFFF_FFFF, 4'd4, rbd_pkg::ST_BUSY},
        // Longest run: 131 bytes, seventeen result words.
        '{8'hFF, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'h5A, 1'b0, 1'b0, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        // Run of five zero bytes.
        '{8'h81, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'h00, 1'b0, 1'b1, 64'h0, 4'd5, rbd_pkg::ST_BUSY},
        // Literal of three bytes.
        '{8'h02, 1'b0, 1'b1, 64'h0, 4'd0, rbd_pkg::ST_BUSY},
        '{8'h01, 1'b0, 1'b1, 64'h01, 4'd1, rbd_pkg::ST_BUSY},
        '{8'h80, 1'b0, 1'b1, 64'h80, 4'd1, rbd_pkg::ST_BUSY},
        '{8'h7E, 1'b0, 1'b0, 64'h0, 4'd0, rbd_pkg::ST_BUSY}
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte      = 8'h00;
    logic        last         = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [63:0] out_bytes;
    logic [3:0]  out_count;
    logic        end_of_burst;
    logic [1:0]  status;

    rle_byte_decoder_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_bytes    (out_bytes),
        .out_count    (out_count),
        .end_of_burst (end_of_burst),
        .status       (status)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Behavioral decoder. Its state starts at the reset values, and it is
    // stepped once per input word, in the order the words are sent.
    // ------------------------------------------------------------------------
    logic [3:0]  hdr_idx   = '0;
    logic [63:0] tgt_size  = '0;
    logic [63:0] wr_count  = '0;
    logic [1:0]  phase     = rbd_pkg::PH_TOKEN;
    logic [7:0]  left      = '0;
    logic        done      = 1'b0;

    logic [7:0]  dec_buf [$];      // bytes decoded from the current word
    dec_result_t burst_q [$];      // result words of the current word
    dec_result_t expected_q [$];   // result words still owed by the block

    int err_count  = 0;
    int words_sent = 0;
    int burst_left = 0;
    int cyc        = 0;

    // Appends one decoded byte unless the target size is already met.
    function automatic void put_byte(input logic [7:0] v);
        if (wr_count < tgt_size)
        begin
            dec_buf.insert(dec_buf.size(), v);
            wr_count++;
        end
    endfunction

    function automatic void put_run(input logic [7:0] v, input logic [7:0] n);
        for (int i = 0; i < n; i++)
            put_byte(v);
    endfunction

    // Steps the decoder by one compressed byte and leaves the resulting
    // words in burst_q.
    function automatic void decode_word(input logic [7:0] b, input logic lst);
        logic [1:0]  st;
        int          nres;
        int          idx;
        dec_result_t r;

        dec_buf.delete();
        burst_q.delete();
        if (!done)
        begin
            if (hdr_idx < rbd_pkg::HDR_BYTES)
            begin
                tgt_size = tgt_size | ({56'd0, b} << (8 * hdr_idx));
                hdr_idx++;
                if (lst)
                    hdr_idx = rbd_pkg::HDR_BYTES;
            end
            else if (phase == rbd_pkg::PH_LITERAL)
            begin
                put_byte(b);
                if (left > 0)
                    left--;
                if (left == 0)
                    phase = rbd_pkg::PH_TOKEN;
            end
            else if (phase == rbd_pkg::PH_RUN)
            begin
                put_run(b, left);
                left  = '0;
                phase = rbd_pkg::PH_TOKEN;
            end
            else
            begin
                // Token byte; the unused phase code also lands here.
                if (b < rbd_pkg::LIT_LIMIT)
                begin
                    phase = rbd_pkg::PH_LITERAL;
                    left  = b + 8'd1;
                end
                else
                begin
                    phase = rbd_pkg::PH_RUN;
                    left  = (b & rbd_pkg::RUN_MASK) + rbd_pkg::RUN_BIAS;
                end
            end

            if (hdr_idx >= rbd_pkg::HDR_BYTES)
            begin
                if (lst)
                begin
                    // An open literal or a run without its value is padded
                    // with zero bytes.
                    if (phase == rbd_pkg::PH_LITERAL || phase == rbd_pkg::PH_RUN)
                        put_run(8'h00, left);
                    phase = rbd_pkg::PH_TOKEN;
                    left  = '0;
                end
                if (wr_count >= tgt_size || lst)
                begin
                    done  = 1'b1;
                    phase = rbd_pkg::PH_TOKEN;
                    left  = '0;
                end
            end
        end

        if (done)
            st = (wr_count >= tgt_size) ? rbd_pkg::ST_DONE : rbd_pkg::ST_TRUNC;
        else
            st = rbd_pkg::ST_BUSY;

        nres = (dec_buf.size() == 0) ? 1 : (dec_buf.size() + BPR - 1) / BPR;
        for (int k = 0; k < nres; k++)
        begin
            r      = '0;
            r.st   = st;
            r.eob  = (k == nres - 1);
            for (int j = 0; j < BPR; j++)
            begin
                idx = k * BPR + j;
                if (idx < dec_buf.size())
                begin
                    r.data = r.data | ({56'd0, dec_buf[idx]} << (8 * j));
                    r.cnt  = r.cnt + 4'd1;
                end
            end
            burst_q.insert(burst_q.size(), r);
        end
    endfunction

    // Random byte with extra weight on the two extremes.
    function automatic logic [7:0] rand_byte();
        unique case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Words go out in bursts of random length; between bursts
    // in_valid drops for a random pause. Long bursts give stretches with no
    // idling at all. The expected words are queued as soon as a word is put
    // on the bus, since a presented word is always accepted eventually.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic lst,
                             input logic fixed, input dec_result_t fixed_res);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
        end
        decode_word(b, lst);
        if (fixed)
            expected_q.insert(expected_q.size(), fixed_res);
        else
            foreach (burst_q[i])
                expected_q.insert(expected_q.size(), burst_q[i]);
        in_valid <= 1'b1;
        in_byte  <= b;
        last     <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        words_sent++;
    endtask

    // Builds the bytes of one random token. Most are well-formed literals or
    // runs; a few are lone noise bytes or literals cut short, which knock the
    // token framing out of step.
    task automatic plan_token(ref logic [7:0] plan_q [$]);
        int k;
        int len;

        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            plan_q.insert(plan_q.size(), rand_byte());
        end
        else if (k <= 4)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(0, 7);
            plan_q.insert(plan_q.size(), 8'(len));
            if (k == 1)
                len = $urandom_range(0, len);
            for (int i = 0; i <= len; i++)
                plan_q.insert(plan_q.size(), rand_byte());
        end
        else
        begin
            plan_q.insert(plan_q.size(), 8'h80 | 8'($urandom_range(0, 127)));
            plan_q.insert(plan_q.size(), rand_byte());
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver. The stall behavior switches at random between always
    // ready, coin flips, rare ready, and long alternating stretches.
    // ------------------------------------------------------------------------
    logic [1:0] stall_mode = 2'd0;
    int         hold_left  = 0;

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 97 == 0)
            stall_mode <= 2'($urandom_range(0, 3));
        unique case (stall_mode)
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2: out_ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (hold_left == 0)
                begin
                    out_ready <= ~out_ready;
                    hold_left <= $urandom_range(1, 16);
                end
                else
                begin
                    hold_left <= hold_left - 1;
                end
            end
        endcase
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Checker. Every accepted result word is compared with the oldest
    // expected word.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        dec_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("result word with none expected", out_bytes, 64'h0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_bytes !== want.data)
                    report_mismatch("out_bytes", out_bytes, want.data);
                if (out_count !== want.cnt)
                    report_mismatch("out_count", {60'd0, out_count}, {60'd0, want.cnt});
                if (end_of_burst !== want.eob)
                    report_mismatch("end_of_burst", {63'd0, end_of_burst},
                                    {63'd0, want.eob});
                if (status !== want.st)
                    report_mismatch("status", {62'd0, status}, {62'd0, want.st});
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0]  plan_q [$];
        dec_result_t fres;
        int          rem;
        int          c;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: header, shortest literal and run, longest run.
        foreach (dir_tab[i])
        begin
            fres = '{data: dir_tab[i].f_data, cnt: dir_tab[i].f_cnt,
                     eob: 1'b1, st: dir_tab[i].f_st};
            send_word(dir_tab[i].data, dir_tab[i].lst, dir_tab[i].fixed, fres);
        end

        // Random part. It stops early if the stream comes within 300 bytes
        // of its target, so that the closing section can land on it exactly.
        while (words_sent < RAND_WORDS && tgt_size - wr_count >= 64'd300)
        begin
            if (plan_q.size() == 0)
                plan_token(plan_q);
            send_word(plan_q.pop_front(), 1'b0, 1'b0, '0);
        end

        // Close whatever token is still open.
        if (phase == rbd_pkg::PH_RUN)
            send_word(rand_byte(), 1'b0, 1'b0, '0);
        while (phase == rbd_pkg::PH_LITERAL)
            send_word(rand_byte(), 1'b0, 1'b0, '0);

        // Runs sized so that between 60 and 120 bytes of the target remain.
        while (tgt_size - wr_count > 64'd120)
        begin
            rem = int'(tgt_size - wr_count);
            c   = (rem - 60 > 131) ? 131 : rem - 60;
            send_word(8'h80 | 8'(c - 4), 1'b0, 1'b0, '0);
            send_word(rand_byte(), 1'b0, 1'b0, '0);
        end

        // The longest literal, cut off by the final byte. Its zero padding
        // overshoots the target and must be clipped, so the stream ends
        // complete.
        rem = int'(tgt_size - wr_count);
        send_word(8'h7F, 1'b0, 1'b0, '0);
        repeat (rem / 2)
            send_word(rand_byte(), 1'b0, 1'b0, '0);
        send_word(rand_byte(), 1'b1, 1'b0, '0);

        // Words after the end of the stream are ignored but still answered.
        repeat ($urandom_range(3, 6))
            send_word(rand_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);

        if (err_count == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
